/* sv/json_value_extent_scanner_top_macros.svh */
// Assertion macros used by the checker file of the value extent scanner.
`ifndef JSON_VALUE_EXTENT_SCANNER_TOP_MACROS_SVH
`define JSON_VALUE_EXTENT_SCANNER_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define JVES_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define JVES_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/jves_pkg.sv */
// Types and constants of the value extent scanner.
`timescale 1ns / 1ps

package jves_pkg;

  localparam int DEPTH_BITS_DEF  = 8;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int LEN_W           = 16;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_SKIP    = 2'd1,
    PH_BRACKET = 2'd2,
    PH_PLAIN   = 2'd3
  } phase_t;

  typedef struct packed {
    logic             in_value;
    logic             value_end;
    logic [LEN_W-1:0] value_length;
    logic             overflow;
  } result_t;

endpackage

/* sv/jves_core.sv */
// Scan state registers and the per-byte update logic.
`timescale 1ns / 1ps

module jves_core
  import jves_pkg::*;
#(
  parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       start_value,
  output result_t    res
);

  phase_t                 scan_phase, scan_phase_next;
  logic                   square_mode, square_mode_next;
  logic                   inside_string, inside_string_next;
  logic                   escape_pending, escape_pending_next;
  logic [DEPTH_BITS-1:0]  nest_depth, nest_depth_next;
  logic [LENGTH_BITS-1:0] byte_count, byte_count_next;
  logic                   overflow_seen, overflow_seen_next;
  logic                   in_value_c, value_end_c;
  logic [LEN_W-1:0]       length_out;

  always_comb begin
    logic       blank;
    logic       ins_t, esc_t, do_count;
    logic [7:0] openc, closec;
    scan_phase_next     = scan_phase;
    square_mode_next    = square_mode;
    inside_string_next  = inside_string;
    escape_pending_next = escape_pending;
    nest_depth_next     = nest_depth;
    byte_count_next     = byte_count;
    overflow_seen_next  = overflow_seen;
    in_value_c          = 1'b0;
    value_end_c         = 1'b0;
    do_count            = 1'b0;

    if (start_value) begin
      scan_phase_next     = PH_SKIP;
      square_mode_next    = 1'b0;
      inside_string_next  = 1'b0;
      escape_pending_next = 1'b0;
      nest_depth_next     = '0;
      byte_count_next     = '0;
      overflow_seen_next  = 1'b0;
    end

    // Quote and escape tracking; a backslash toggles the escape.
    if (data_byte == CH_BSLASH) begin
      ins_t = inside_string_next;
      esc_t = !escape_pending_next;
    end else begin
      ins_t = inside_string_next ^ ((data_byte == CH_QUOTE) && !escape_pending_next);
      esc_t = 1'b0;
    end

    blank  = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
    openc  = square_mode_next ? CH_LBRACK : CH_LBRACE;
    closec = square_mode_next ? CH_RBRACK : CH_RBRACE;

    if (scan_phase_next == PH_SKIP && !(blank || data_byte == CH_COLON)) begin
      if (data_byte == CH_LBRACE || data_byte == CH_LBRACK) begin
        scan_phase_next  = PH_BRACKET;
        square_mode_next = (data_byte == CH_LBRACK);
        nest_depth_next  = DEPTH_BITS'(1);
        byte_count_next  = LENGTH_BITS'(1);
        in_value_c       = 1'b1;
      end else begin
        scan_phase_next = PH_PLAIN;
      end
    end else if (scan_phase_next == PH_BRACKET) begin
      inside_string_next  = ins_t;
      escape_pending_next = esc_t;
      if (!ins_t && data_byte == openc) begin
        if (nest_depth_next == '1) begin
          overflow_seen_next = 1'b1;
        end else begin
          nest_depth_next = nest_depth_next + DEPTH_BITS'(1);
        end
      end else if (!ins_t && data_byte == closec && nest_depth_next != '0) begin
        nest_depth_next = nest_depth_next - DEPTH_BITS'(1);
      end
      do_count   = 1'b1;
      in_value_c = 1'b1;
      if (nest_depth_next == '0) begin
        value_end_c     = 1'b1;
        scan_phase_next = PH_IDLE;
      end
    end

    // A byte that leaves the skip phase for a plain value is also handled as a plain byte.
    if (scan_phase_next == PH_PLAIN) begin
      if (!inside_string_next && (data_byte == CH_COMMA || data_byte == CH_RBRACE)) begin
        value_end_c     = 1'b1;
        scan_phase_next = PH_IDLE;
      end else begin
        inside_string_next  = ins_t;
        escape_pending_next = esc_t;
        do_count            = 1'b1;
        in_value_c          = 1'b1;
      end
    end

    if (do_count) begin
      if (byte_count_next == '1) begin
        overflow_seen_next = 1'b1;
      end else begin
        byte_count_next = byte_count_next + LENGTH_BITS'(1);
      end
    end
  end

  generate
    if (LENGTH_BITS > LEN_W) begin : g_len_sat
      assign length_out = (|byte_count_next[LENGTH_BITS-1:LEN_W]) ? '1
                                                                  : byte_count_next[LEN_W-1:0];
    end else begin : g_len_ext
      assign length_out = LEN_W'(byte_count_next);
    end
  endgenerate

  assign res.in_value     = in_value_c;
  assign res.value_end    = value_end_c;
  assign res.value_length = length_out;
  assign res.overflow     = overflow_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase     <= PH_IDLE;
      square_mode    <= 1'b0;
      inside_string  <= 1'b0;
      escape_pending <= 1'b0;
      nest_depth     <= '0;
      byte_count     <= '0;
      overflow_seen  <= 1'b0;
    end else if (step) begin
      scan_phase     <= scan_phase_next;
      square_mode    <= square_mode_next;
      inside_string  <= inside_string_next;
      escape_pending <= escape_pending_next;
      nest_depth     <= nest_depth_next;
      byte_count     <= byte_count_next;
      overflow_seen  <= overflow_seen_next;
    end
  end

endmodule

/* sv/jves_outbuf.sv */
// Result register with a skid stage for the output channel.
`timescale 1ns / 1ps

module jves_outbuf
  import jves_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;

  // The skid stage only fills when the result register is held by a stall.
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

/* sv/json_value_extent_scanner_top.sv */
// Top level of the JSON value extent scanner.
// The input channel takes one byte of JSON text per transfer, with start_value
// set on the byte that follows a key's closing quote. Every input transfer
// yields exactly one output transfer carrying in_value, value_end, the running
// value_length and the overflow flag for that byte, in order.
// The result of an accepted byte is registered in the result register, or in
// the skid stage while that register is held. Throughput is one byte per cycle
// while in_stall is low, set by the single register stage that holds the scan state.
// When the receiver stalls, the result register holds its payload and one
// further result goes into a skid stage; in_stall rises only once that stage
// is full and falls as soon as it drains.
// Reset (rst, synchronous) returns the scan to idle, clears depth, length and
// overflow, and empties both output stages.
`timescale 1ns / 1ps

module json_value_extent_scanner_top
  import jves_pkg::*;
#(
  parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             start_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             in_value,
  output logic             value_end,
  output logic [LEN_W-1:0] value_length,
  output logic             overflow
);

  logic    step;
  logic    buf_full;
  result_t core_res;
  result_t out_res;

  assign in_stall = buf_full;
  assign step     = in_valid && !buf_full;

  jves_core #(
    .DEPTH_BITS  (DEPTH_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (data_byte),
    .start_value (start_value),
    .res         (core_res)
  );

  jves_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (core_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign in_value     = out_res.in_value;
  assign value_end    = out_res.value_end;
  assign value_length = out_res.value_length;
  assign overflow     = out_res.overflow;

endmodule

/* sv/jves_checker.sv */
// Port-level checker for the value extent scanner, bound to the top level.
`timescale 1ns / 1ps
`include "json_value_extent_scanner_top_macros.svh"

module jves_checker
  import jves_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             in_value,
  input logic             value_end,
  input logic [LEN_W-1:0] value_length,
  input logic             overflow
);

  `JVES_ASSERT_RST(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(in_value) && $stable(value_end) && $stable(value_length) && $stable(overflow), "stalled result changed")
  `JVES_ASSERT_ALL(a_reset_empty, clk, rst |=> !out_valid && !in_stall, "output stages not empty after reset")
  `JVES_ASSERT_RST(a_stall_cause, clk, rst, $rose(in_stall) |-> $past(out_valid && out_stall && in_valid), "input stalled without a stalled result")
  `JVES_ASSERT_RST(a_close_len, clk, rst, out_valid && value_end && in_value |-> value_length != '0, "closing bracket reported with zero length")

endmodule

bind json_value_extent_scanner_top jves_checker u_jves_checker (.*);

/* sim/tb.sv */
// Self-checking testbench for the JSON value extent scanner top level.
`timescale 1ns / 1ps

module tb;
  import jves_pkg::*;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  localparam int    DEPTH_MAX     = (1 << DEPTH_BITS_DEF) - 1;
  localparam longint LENGTH_MAX   = (64'd1 << LENGTH_BITS_DEF) - 1;
  localparam int    N_DIR         = 25;
  localparam int    RANDOM_BYTES  = 600;
  localparam int    DEEP_OPENS    = 300;
  localparam int    LONG_SCAN_LEN = 320;
  localparam int    HOLD_CYCLES   = 300;
  localparam int    RUN_LIMIT     = 600000;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       typed;
    result_t    res;
  } dir_row_t;

  typedef struct packed {
    logic    typed;
    result_t res;
  } byte_tag_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       data_byte = 8'h00;
  logic             start_value = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             in_value;
  logic             value_end;
  logic [LEN_W-1:0] value_length;
  logic             overflow;

  // Scan state of the predictor.
  phase_t sc_phase = PH_IDLE;
  logic   sc_square = 1'b0;
  logic   sc_in_str = 1'b0;
  logic   sc_esc = 1'b0;
  int     sc_depth = 0;
  longint sc_count = 0;
  logic   sc_ovf = 1'b0;

  result_t   extent_q[$];
  byte_tag_t typed_q[$];
  logic [7:0] text_q[$];

  bit idle_on = 1'b0;
  bit hold_req = 1'b0;
  int err_count = 0;
  int cycle_count = 0;
  int field_bytes = 0;

  // Rows with typed expectations are the ones whose result is plain to see;
  // the others are checked against the predictor.
  dir_row_t dir_tab [N_DIR] = '{
    '{8'h78,     1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
    '{CH_SPACE,  1'b1, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
    '{CH_COLON,  1'b0, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
    '{CH_LBRACE, 1'b0, 1'b1, '{1'b1, 1'b0, 16'd1, 1'b0}},
    '{CH_QUOTE,  1'b0, 1'b0, '0},
    '{CH_RBRACE, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_QUOTE,  1'b0, 1'b0, '0},
    '{CH_LBRACK, 1'b0, 1'b0, '0},
    '{CH_RBRACE, 1'b0, 1'b0, '0},
    '{8'hFF,     1'b0, 1'b0, '0},
    '{8'h00,     1'b1, 1'b1, '{1'b1, 1'b0, 16'd1, 1'b0}},
    '{CH_QUOTE,  1'b0, 1'b0, '0},
    '{CH_COMMA,  1'b0, 1'b0, '0},
    '{CH_BSLASH, 1'b0, 1'b0, '0},
    '{CH_QUOTE,  1'b0, 1'b0, '0},
    '{CH_QUOTE,  1'b0, 1'b0, '0},
    '{CH_COMMA,  1'b0, 1'b0, '0},
    '{CH_RBRACE, 1'b1, 1'b1, '{1'b0, 1'b1, 16'd0, 1'b0}},
    '{CH_CR,     1'b1, 1'b1, '{1'b0, 1'b0, 16'd0, 1'b0}},
    '{CH_LBRACK, 1'b0, 1'b1, '{1'b1, 1'b0, 16'd1, 1'b0}},
    '{CH_RBRACK, 1'b0, 1'b1, '{1'b1, 1'b1, 16'd2, 1'b0}},
    '{8'h37,     1'b1, 1'b1, '{1'b1, 1'b0, 16'd1, 1'b0}},
    '{CH_LBRACE, 1'b1, 1'b1, '{1'b1, 1'b0, 16'd1, 1'b0}}
  };

  json_value_extent_scanner_top #(
    .DEPTH_BITS (DEPTH_BITS_DEF),
    .LENGTH_BITS(LENGTH_BITS_DEF)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .start_value (start_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .in_value    (in_value),
    .value_end   (value_end),
    .value_length(value_length),
    .overflow    (overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void bump_length();
    if (sc_count >= LENGTH_MAX) begin
      sc_count = LENGTH_MAX;
      sc_ovf = 1'b1;
    end else begin
      sc_count++;
    end
  endfunction

  // A backslash toggles the escape, so a doubled backslash leaves none behind.
  function automatic void follow_quotes(input logic [7:0] c);
    if (c == CH_BSLASH) begin
      sc_esc = !sc_esc;
    end else begin
      if (c == CH_QUOTE && !sc_esc) sc_in_str = !sc_in_str;
      sc_esc = 1'b0;
    end
  endfunction

  function automatic result_t scan_byte(input logic [7:0] c, input logic s);
    result_t    r;
    logic [7:0] open_c;
    logic [7:0] close_c;
    r = '0;
    if (s) begin
      sc_phase = PH_SKIP;
      sc_square = 1'b0;
      sc_in_str = 1'b0;
      sc_esc = 1'b0;
      sc_depth = 0;
      sc_count = 0;
      sc_ovf = 1'b0;
    end
    if (sc_phase == PH_SKIP &&
        !(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_COLON)) begin
      if (c == CH_LBRACE || c == CH_LBRACK) begin
        sc_phase = PH_BRACKET;
        sc_square = (c == CH_LBRACK);
        sc_depth = 1;
        sc_count = 1;
        r.in_value = 1'b1;
      end else begin
        sc_phase = PH_PLAIN;
      end
    end else if (sc_phase == PH_BRACKET) begin
      open_c = sc_square ? CH_LBRACK : CH_LBRACE;
      close_c = sc_square ? CH_RBRACK : CH_RBRACE;
      follow_quotes(c);
      if (!sc_in_str && c == open_c) begin
        if (sc_depth >= DEPTH_MAX) sc_ovf = 1'b1;
        else sc_depth++;
      end else if (!sc_in_str && c == close_c && sc_depth > 0) begin
        sc_depth--;
      end
      bump_length();
      r.in_value = 1'b1;
      if (sc_depth == 0) begin
        r.value_end = 1'b1;
        sc_phase = PH_IDLE;
      end
    end
    // The byte that ends the skip phase of a plain value lands here as well.
    if (sc_phase == PH_PLAIN) begin
      if (!sc_in_str && (c == CH_COMMA || c == CH_RBRACE)) begin
        r.value_end = 1'b1;
        sc_phase = PH_IDLE;
      end else begin
        follow_quotes(c);
        bump_length();
        r.in_value = 1'b1;
      end
    end
    r.value_length = (sc_count > 65535) ? 16'hFFFF : sc_count[15:0];
    r.overflow = sc_ovf;
    return r;
  endfunction

  // Input side: every accepted byte yields one expected result.
  always @(posedge clk) begin : accept_mon
    result_t   pred;
    byte_tag_t tag;
    if (!rst && in_valid && !in_stall) begin
      pred = scan_byte(data_byte, start_value);
      tag = typed_q.pop_front();
      extent_q.push_back(tag.typed ? tag.res : pred);
    end
  end

  always @(posedge clk) begin : result_mon
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{in_value, value_end, value_length, overflow};
      if (extent_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: result with none pending: in=%0b end=%0b len=%0d ovf=%0b",
                   $time, got.in_value, got.value_end, got.value_length, got.overflow);
      end else begin
        want = extent_q.pop_front();
        if (got.in_value !== want.in_value || got.value_end !== want.value_end ||
            got.value_length !== want.value_length || got.overflow !== want.overflow) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: mismatch: expected in=%0b end=%0b len=%0d ovf=%0b, got in=%0b end=%0b len=%0d ovf=%0b",
                     $time, want.in_value, want.value_end, want.value_length, want.overflow,
                     got.in_value, got.value_end, got.value_length, got.overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("json_value_extent_scanner_top test failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s,
                           input logic typed = 1'b0, input result_t tv = '0);
    byte_tag_t tag;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    tag.typed = typed;
    tag.res = tv;
    typed_q.push_back(tag);
    in_valid <= 1'b1;
    data_byte <= b;
    start_value <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 6))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      5: return CH_CR;
      default: return CH_COLON;
    endcase
  endfunction

  // Printable byte that is neither a quote nor a backslash.
  function automatic logic [7:0] pick_text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  function automatic void add_string();
    text_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 4) == 0) begin
        text_q.push_back(CH_BSLASH);
        case ($urandom_range(0, 2))
          0: text_q.push_back(CH_QUOTE);
          1: text_q.push_back(CH_BSLASH);
          default: text_q.push_back(8'h6E);
        endcase
      end else begin
        text_q.push_back(pick_text_char());
      end
    end
    text_q.push_back(CH_QUOTE);
  endfunction

  function automatic void add_scalar();
    case ($urandom_range(0, 5))
      0: ;
      1, 2: add_string();
      default: repeat ($urandom_range(1, 5))
        text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h30, 8'h39))
                                              : 8'($urandom_range(8'h61, 8'h7A)));
    endcase
  endfunction

  function automatic void add_value(input int lvl);
    if (lvl < 4 && $urandom_range(0, 9) < 4) add_container(lvl + 1);
    else add_scalar();
  endfunction

  function automatic void add_container(input int lvl);
    bit obj;
    obj = ($urandom_range(0, 1) != 0);
    text_q.push_back(obj ? CH_LBRACE : CH_LBRACK);
    for (int i = 0; i < $urandom_range(0, 3); i++) begin
      if (i > 0) text_q.push_back(CH_COMMA);
      if ($urandom_range(0, 3) == 0) text_q.push_back(pick_blank());
      if (obj) begin
        add_string();
        text_q.push_back(CH_COLON);
      end
      add_value(lvl);
    end
    text_q.push_back(obj ? CH_RBRACE : CH_RBRACK);
  endfunction

  // One key's value as it follows the closing quote, sometimes cut short so
  // that the next start aborts it, then a few bytes the block should ignore.
  task automatic send_field();
    int cut;
    text_q.delete();
    repeat ($urandom_range(0, 3)) text_q.push_back(pick_blank());
    if ($urandom_range(0, 1)) add_container(1);
    else add_scalar();
    text_q.push_back($urandom_range(0, 1) ? CH_COMMA : CH_RBRACE);
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, text_q.size());
      while (text_q.size() > cut) void'(text_q.pop_back());
    end
    foreach (text_q[i]) begin
      send_byte(text_q[i], i == 0);
      field_bytes++;
    end
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    idle_on = 1'b1;
    for (int i = 0; i < N_DIR; i++)
      send_byte(dir_tab[i].data, dir_tab[i].start, dir_tab[i].typed, dir_tab[i].res);

    // Long hold-off on the output while the input keeps offering bytes.
    idle_on = 1'b0;
    hold_req = 1'b1;
    while (field_bytes < RANDOM_BYTES) begin
      repeat (8) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 12)) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            field_bytes++;
          end
        end else begin
          send_field();
        end
      end
      idle_on = ($urandom_range(0, 9) < 7);
    end

    // Nest past the depth limit, then a short run of plain bytes inside it.
    idle_on = 1'b0;
    send_byte(CH_LBRACK, 1'b1);
    repeat (DEEP_OPENS - 1) send_byte(CH_LBRACK, 1'b0);
    repeat (LONG_SCAN_LEN - DEEP_OPENS) send_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
    send_byte(CH_RBRACK, 1'b0);

    repeat (10) send_field();
    in_valid <= 1'b0;

    while (extent_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("json_value_extent_scanner_top test passed");
    end else begin
      $display("json_value_extent_scanner_top test failed");
    end
    $finish;
  end

endmodule
